@@ rtl/sfr_pkg.sv @@
// Shared types and constants for the stepper frequency ramp block.
// No dependencies; every other file uses this package.
package sfr_pkg;

  // Item operation codes
  localparam logic [1:0] OP_RUN   = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Move direction codes
  localparam logic [1:0] DIR_RIGHT = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  // Configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_AXIS_MODE  = 3'd0;
  localparam logic [2:0] REG_FREQ_LVL0  = 3'd1;
  localparam logic [2:0] REG_FREQ_LVL1  = 3'd2;
  localparam logic [2:0] REG_FREQ_LVL2  = 3'd3;
  localparam logic [2:0] REG_FREQ_LVL3  = 3'd4;
  localparam logic [2:0] REG_STEP_TICKS = 3'd5;

  localparam int CFG_AW = 5;

  // Register reset values
  localparam logic [15:0] RST_FREQ_LVL0  = 16'd1000;
  localparam logic [15:0] RST_FREQ_LVL1  = 16'd1250;
  localparam logic [15:0] RST_FREQ_LVL2  = 16'd2000;
  localparam logic [15:0] RST_FREQ_LVL3  = 16'd2500;
  localparam logic [15:0] RST_STEP_TICKS = 16'd50;
  localparam logic [15:0] RST_CUR_FREQ   = 16'd2000;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  move_dir;
    logic [31:0] move_ticks;
  } sfr_in_t;

  typedef struct packed {
    logic [15:0] pulse_freq;
    logic        dir_first;
    logic        dir_second;
    logic        drive_on;
    logic        freq_changed;
  } sfr_out_t;

  typedef struct packed {
    logic        axis_mode;
    logic [15:0] freq_level0;
    logic [15:0] freq_level1;
    logic [15:0] freq_level2;
    logic [15:0] freq_level3;
    logic [15:0] step_ticks;
  } sfr_cfg_t;

endpackage

@@ rtl/sfr_if.sv @@
// Valid/ready channel interfaces for the ramp block's item and result streams.
// Depends on sfr_pkg for the payload types.
interface sfr_in_if;
  logic            valid;
  logic            ready;
  sfr_pkg::sfr_in_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sfr_out_if;
  logic             valid;
  logic             ready;
  sfr_pkg::sfr_out_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sfr_ramp_core.sv @@
// Ramp state and per-item next-state logic: counters, level table walk, directions.
// Depends on sfr_pkg.
module sfr_ramp_core #(
  parameter int LEVELS = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  sfr_pkg::sfr_in_t  item,
  input  sfr_pkg::sfr_cfg_t cfg,
  output sfr_pkg::sfr_out_t result
);
  import sfr_pkg::*;

  localparam int LIW = $clog2(LEVELS);
  localparam int PW  = 16 + $clog2(LEVELS + 1);

  logic [31:0]     run_count_r, run_count_nxt;
  logic [31:0]     brake_count_r, brake_count_nxt;
  logic [31:0]     target_ticks_r, target_ticks_nxt;
  logic [1:0]      target_dir_r, target_dir_nxt;
  logic [15:0]     cur_freq_r, cur_freq_nxt;
  logic [LIW-1:0]  level_index_r, level_index_nxt;
  logic            dir_first_r, dir_first_nxt;
  logic            dir_second_r, dir_second_nxt;
  logic            drive_r, drive_nxt;
  logic            changed;
  logic            tbl_load;

  logic [PW-1:0]   prod [LEVELS+1];
  logic [LIW-1:0]  lat_idx;
  logic            run_hit;
  logic [LIW-1:0]  run_sel;
  logic            brk_hit;
  logic [LIW-1:0]  brk_off;
  logic [LIW-1:0]  brk_sel;
  logic            brk_zero;
  logic            moving;
  logic            do_brake;
  logic [15:0]     run_f;
  logic [15:0]     brk_f;

  function automatic logic [15:0] level_freq(input logic [LIW-1:0] idx,
                                             input sfr_cfg_t c);
    logic [15:0] f;
    case (32'(idx))
      0:       f = c.freq_level0;
      1:       f = c.freq_level1;
      2:       f = c.freq_level2;
      default: f = c.freq_level3;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Level thresholds: step_ticks times each constant level count
  always_comb begin
    for (int k = 0; k <= LEVELS; k++) begin
      prod[k] = PW'(cfg.step_ticks) * PW'(k);
    end
  end

  // Highest table entry equal to the current frequency; hold if none
  always_comb begin
    lat_idx = level_index_r;
    for (int i = 0; i < LEVELS; i++) begin
      if (level_freq(LIW'(i), cfg) == cur_freq_r) lat_idx = LIW'(i);
    end
  end

  // Accelerating level: first level whose window still covers run_count
  always_comb begin
    run_hit = 1'b0;
    run_sel = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (run_count_r < 32'(prod[i+1])) begin
        run_hit = 1'b1;
        run_sel = LIW'(i);
      end
    end
  end

  // Braking level: first step down from the recorded index not yet passed
  always_comb begin
    brk_hit = 1'b0;
    brk_off = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (LIW'(i) <= level_index_r && brake_count_r <= 32'(prod[i])) begin
        brk_hit = 1'b1;
        brk_off = LIW'(i);
      end
    end
    brk_sel  = level_index_r - brk_off;
    brk_zero = !brk_hit && (brake_count_r > 32'(prod[LEVELS-1]));
  end

  assign run_f    = level_freq(run_sel, cfg);
  assign brk_f    = level_freq(brk_sel, cfg);
  assign moving   = run_count_r < target_ticks_r;
  assign do_brake = (item.op == OP_STOP) || (item.op == OP_RUN && !moving);

  always_comb begin
    run_count_nxt    = run_count_r;
    brake_count_nxt  = brake_count_r;
    target_ticks_nxt = target_ticks_r;
    target_dir_nxt   = target_dir_r;
    cur_freq_nxt     = cur_freq_r;
    level_index_nxt  = level_index_r;
    dir_first_nxt    = dir_first_r;
    dir_second_nxt   = dir_second_r;
    drive_nxt        = drive_r;
    changed          = 1'b0;
    tbl_load         = 1'b0;

    case (item.op)
      OP_START: begin
        target_dir_nxt   = item.move_dir;
        target_ticks_nxt = item.move_ticks;
        run_count_nxt    = '0;
        level_index_nxt  = lat_idx;
      end
      OP_RUN, OP_STOP: begin
        run_count_nxt   = sat_inc(run_count_r);
        brake_count_nxt = sat_inc(brake_count_r);
        if (item.op == OP_RUN && moving) begin
          if (run_count_r < 32'(prod[LEVELS])) level_index_nxt = lat_idx;
          if (run_hit && run_f != cur_freq_r) begin
            cur_freq_nxt = run_f;
            changed      = 1'b1;
            tbl_load     = 1'b1;
          end
          drive_nxt       = 1'b1;
          brake_count_nxt = 32'd1;
        end
        if (do_brake) begin
          if (brk_hit) begin
            if (brk_f != cur_freq_r) begin
              cur_freq_nxt = brk_f;
              drive_nxt    = 1'b1;
              changed      = 1'b1;
              tbl_load     = 1'b1;
            end
          end else if (brk_zero) begin
            changed      = cur_freq_r != 16'd0;
            cur_freq_nxt = 16'd0;
            drive_nxt    = 1'b0;
          end
        end
        // Directions follow only a table load (zero forcing leaves them alone)
        if (tbl_load) begin
          if (!cfg.axis_mode) begin
            if (target_dir_r == DIR_RIGHT) dir_first_nxt = 1'b1;
            else if (target_dir_r == DIR_LEFT) dir_first_nxt = 1'b0;
          end else begin
            if (target_dir_r == DIR_UP) begin
              dir_first_nxt  = 1'b1;
              dir_second_nxt = 1'b0;
            end else if (target_dir_r == DIR_DOWN) begin
              dir_first_nxt  = 1'b0;
              dir_second_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_count_r    <= '0;
      brake_count_r  <= '0;
      target_ticks_r <= '0;
      target_dir_r   <= DIR_RIGHT;
      cur_freq_r     <= RST_CUR_FREQ;
      level_index_r  <= '0;
      dir_first_r    <= 1'b0;
      dir_second_r   <= 1'b0;
      drive_r        <= 1'b0;
    end else if (fire) begin
      run_count_r    <= run_count_nxt;
      brake_count_r  <= brake_count_nxt;
      target_ticks_r <= target_ticks_nxt;
      target_dir_r   <= target_dir_nxt;
      cur_freq_r     <= cur_freq_nxt;
      level_index_r  <= level_index_nxt;
      dir_first_r    <= dir_first_nxt;
      dir_second_r   <= dir_second_nxt;
      drive_r        <= drive_nxt;
    end
  end

  assign result.pulse_freq   = cur_freq_nxt;
  assign result.dir_first    = dir_first_nxt;
  assign result.dir_second   = cfg.axis_mode ? dir_second_nxt : 1'b0;
  assign result.drive_on     = drive_nxt;
  assign result.freq_changed = changed;

endmodule

@@ rtl/stepper_frequency_ramp.sv @@
// Top level of the stepper frequency ramp: APB registers, input and result stages.
// Depends on sfr_pkg, sfr_if.sv (channel interfaces) and sfr_ramp_core.
//
//   channel  | dir | transfer when        | payload
//   ---------+-----+----------------------+------------------------------------------
//   in_if    | in  | valid & ready        | op, move_dir, move_ticks
//   out_if   | out | valid & ready        | pulse_freq, dir_first, dir_second,
//            |     |                      | drive_on, freq_changed
//   APB      | in  | psel&penable&pwrite  | axis_mode, freq_level0..3, step_ticks
//
// One item per cycle sustained while out_ready stays high; each item is held in the
// input register while the ramp core computes its result, then sits in the result
// register until the sink takes it.
// Synchronous active-low reset loads the register defaults and the ramp start state
// (2000 Hz, drive off) and empties both stages.
// When out_ready stays low the result register holds, the input register fills, and
// in_ready drops until the result transfers.
module stepper_frequency_ramp #(
  parameter int LEVELS = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  sfr_in_if.sink                        in_if,
  sfr_out_if.source                     out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sfr_pkg::CFG_AW-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import sfr_pkg::*;

  sfr_cfg_t  cfg_r;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  logic      s1_valid_r;
  sfr_in_t   s1_item_r;
  logic      out_valid_r;
  sfr_out_t  out_data_r;
  sfr_out_t  core_res;
  logic      adv;
  logic      fire;

  // Configuration port: zero wait states, word-aligned registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_mode   <= 1'b0;
      cfg_r.freq_level0 <= RST_FREQ_LVL0;
      cfg_r.freq_level1 <= RST_FREQ_LVL1;
      cfg_r.freq_level2 <= RST_FREQ_LVL2;
      cfg_r.freq_level3 <= RST_FREQ_LVL3;
      cfg_r.step_ticks  <= RST_STEP_TICKS;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_AXIS_MODE:  cfg_r.axis_mode   <= pwdata[0];
        REG_FREQ_LVL0:  cfg_r.freq_level0 <= pwdata[15:0];
        REG_FREQ_LVL1:  cfg_r.freq_level1 <= pwdata[15:0];
        REG_FREQ_LVL2:  cfg_r.freq_level2 <= pwdata[15:0];
        REG_FREQ_LVL3:  cfg_r.freq_level3 <= pwdata[15:0];
        REG_STEP_TICKS: cfg_r.step_ticks  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_AXIS_MODE:  prdata = {31'd0, cfg_r.axis_mode};
      REG_FREQ_LVL0:  prdata = {16'd0, cfg_r.freq_level0};
      REG_FREQ_LVL1:  prdata = {16'd0, cfg_r.freq_level1};
      REG_FREQ_LVL2:  prdata = {16'd0, cfg_r.freq_level2};
      REG_FREQ_LVL3:  prdata = {16'd0, cfg_r.freq_level3};
      REG_STEP_TICKS: prdata = {16'd0, cfg_r.step_ticks};
      default:        prdata = 32'd0;
    endcase
  end

  // Advance whenever the result register is empty or being drained this cycle
  assign adv         = !out_valid_r || out_if.ready;
  assign fire        = s1_valid_r && adv;
  assign in_if.ready = !s1_valid_r || adv;

  // Input register: hold the accepted item until the core consumes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_item_r <= in_if.payload;
    end
  end

  // Ramp state lives in the core and steps once per consumed item
  sfr_ramp_core #(
    .LEVELS (LEVELS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg_r),
    .result (core_res)
  );

  // Result register: drop after a transfer, load on each consumed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= core_res;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.payload = out_data_r;

  // An empty result register always leaves room for a new item
  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input not ready while result register empty");

  // A pending item survives a stalled result register
  a_stage_holds : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r)
    else $error("pending item lost during stall");

  // A result appears only for an item that was waiting in the input register
  a_result_has_item : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result produced without an item");

endmodule

@@ test/tb_stepper_frequency_ramp.sv @@
// Self-checking testbench for stepper_frequency_ramp: ramp item and result streams, APB setup.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv; a scoreboard class predicts results.
module tb_stepper_frequency_ramp;
  import sfr_pkg::*;

  localparam int          RAMP_LEVELS = 4;
  localparam logic [1:0]  OP_UNDEF    = 2'd3;   // ignored by the block, reports held outputs
  localparam int          HOLD_CYCLES = 300;    // long receiver hold-off to back up the input

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // Ramp scoreboard: keeps its own copy of registers and ramp state, predicts one result per
  // accepted item and checks results in order against the queue of predicted outputs.
  class ramp_scoreboard;
    logic        axis_mode;
    logic [15:0] level_tbl [4];
    logic [15:0] step_ticks;
    logic [31:0] run_count, brake_count, target_ticks;
    logic [1:0]  target_dir;
    logic [15:0] cur_freq;
    int unsigned level_index;
    logic        dir_first_q, dir_second_q, drive_q;
    sfr_out_t    predicted_q [$];
    int          mismatches, items_seen, results_seen;

    function new();
      axis_mode    = 1'b0;
      level_tbl[0] = RST_FREQ_LVL0;
      level_tbl[1] = RST_FREQ_LVL1;
      level_tbl[2] = RST_FREQ_LVL2;
      level_tbl[3] = RST_FREQ_LVL3;
      step_ticks   = RST_STEP_TICKS;
      run_count    = '0;
      brake_count  = '0;
      target_ticks = '0;
      target_dir   = DIR_RIGHT;
      cur_freq     = RST_CUR_FREQ;
      level_index  = 0;
      dir_first_q  = 1'b0;
      dir_second_q = 1'b0;
      drive_q      = 1'b0;
      mismatches   = 0;
      items_seen   = 0;
      results_seen = 0;
    endfunction

    function int pending();
      return predicted_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_AXIS_MODE:  axis_mode    = val[0];
        REG_FREQ_LVL0:  level_tbl[0] = val[15:0];
        REG_FREQ_LVL1:  level_tbl[1] = val[15:0];
        REG_FREQ_LVL2:  level_tbl[2] = val[15:0];
        REG_FREQ_LVL3:  level_tbl[3] = val[15:0];
        REG_STEP_TICKS: step_ticks   = val[15:0];
        default: ;
      endcase
    endfunction

    // Entries past the fourth all read the top register
    function logic [15:0] level_freq(longint unsigned i);
      return level_tbl[(i < 3) ? i : 3];
    endfunction

    function void apply_dirs();
      if (!axis_mode) begin
        if (target_dir == DIR_RIGHT) dir_first_q = 1'b1;
        else if (target_dir == DIR_LEFT) dir_first_q = 1'b0;
      end else begin
        if (target_dir == DIR_UP) begin
          dir_first_q  = 1'b1;
          dir_second_q = 1'b0;
        end else if (target_dir == DIR_DOWN) begin
          dir_first_q  = 1'b0;
          dir_second_q = 1'b1;
        end
      end
    endfunction

    // Highest matching entry wins; no match leaves the index alone
    function void relatch_level();
      for (int unsigned i = 0; i < RAMP_LEVELS; i++)
        if (level_freq(i) == cur_freq) level_index = i;
    endfunction

    // Walk down the table from the latched index, then drop to zero with the drive off
    function bit brake_step();
      bit              changed;
      longint unsigned st, bc, top;
      changed = 1'b0;
      st      = step_ticks;
      bc      = brake_count;
      top     = (level_index < RAMP_LEVELS) ? level_index : RAMP_LEVELS - 1;
      for (longint unsigned i = 0; i <= top; i++) begin
        if (bc <= st * i) begin
          if (cur_freq != level_freq(top - i)) begin
            cur_freq = level_freq(top - i);
            apply_dirs();
            drive_q  = 1'b1;
            changed  = 1'b1;
          end
          break;
        end else if (st * (RAMP_LEVELS - 1) < bc) begin
          if (cur_freq != 16'd0) changed = 1'b1;
          cur_freq = 16'd0;
          drive_q  = 1'b0;
        end
      end
      return changed;
    endfunction

    function void note_item(sfr_in_t item);
      bit              changed;
      longint unsigned st, rc;
      sfr_out_t        res;
      changed = 1'b0;
      st      = step_ticks;
      rc      = run_count;
      items_seen++;
      case (item.op)
        OP_START: begin
          target_dir   = item.move_dir;
          target_ticks = item.move_ticks;
          run_count    = '0;
          relatch_level();
        end
        OP_RUN, OP_STOP: begin
          if (item.op == OP_STOP) begin
            changed = brake_step();
          end else if (run_count < target_ticks) begin
            if (rc < st * RAMP_LEVELS) relatch_level();
            for (longint unsigned i = 0; i < RAMP_LEVELS; i++) begin
              if (rc < st * (i + 1)) begin
                if (cur_freq != level_freq(i)) begin
                  cur_freq = level_freq(i);
                  apply_dirs();
                  changed  = 1'b1;
                end
                break;
              end
            end
            drive_q     = 1'b1;
            brake_count = '0;
          end else begin
            changed = brake_step();
          end
          if (run_count != 32'hFFFF_FFFF) run_count++;
          if (brake_count != 32'hFFFF_FFFF) brake_count++;
        end
        default: ;
      endcase
      res.pulse_freq   = cur_freq;
      res.dir_first    = dir_first_q;
      res.dir_second   = axis_mode ? dir_second_q : 1'b0;
      res.drive_on     = drive_q;
      res.freq_changed = changed;
      predicted_q.push_back(res);
    endfunction

    function void check_result(sfr_out_t got);
      sfr_out_t want;
      results_seen++;
      if (predicted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d with nothing predicted: freq=%0d d1=%b d2=%b drv=%b chg=%b",
                   results_seen, got.pulse_freq, got.dir_first, got.dir_second, got.drive_on,
                   got.freq_changed);
        return;
      end
      want = predicted_q.pop_front();
      if (got.pulse_freq !== want.pulse_freq || got.dir_first !== want.dir_first ||
          got.dir_second !== want.dir_second || got.drive_on !== want.drive_on ||
          got.freq_changed !== want.freq_changed) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected freq=%0d d1=%b d2=%b drv=%b chg=%b, got freq=%0d d1=%b d2=%b drv=%b chg=%b",
                   results_seen, want.pulse_freq, want.dir_first, want.dir_second,
                   want.drive_on, want.freq_changed, got.pulse_freq, got.dir_first,
                   got.dir_second, got.drive_on, got.freq_changed);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [CFG_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  ramp_scoreboard sb;
  int             idle_pct;
  int             stall_pct;
  bit             hold_req;
  int             hold_left;
  int             phases_run;

  stepper_frequency_ramp dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // Result side: check each transfer, then pick next cycle's ready. A hold-off request
  // drops ready for a long stretch, counted here, while the sender keeps offering.
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
        if (hold_left > 0) begin
          hold_left--;
          out_ch.ready <= 1'b0;
        end else if (hold_req) begin
          hold_req     = 1'b0;
          hold_left    = HOLD_CYCLES - 1;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
      end
    end
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:     begin idle_pct = 0;  stall_pct = 0;  end
      IDLE_SENDER:   begin idle_pct = 73; stall_pct = 0;  end
      IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 73; end
      default:       begin idle_pct = 8;  stall_pct = 8;  end
    endcase
  endtask

  // Offer one item, idling first at random; return at the edge of its transfer
  // with valid left high so back-to-back items need no second assignment.
  task automatic send_item(input logic [1:0] op, input logic [1:0] dir,
                           input logic [31:0] ticks);
    sfr_in_t item;
    item.op         = op;
    item.move_dir   = dir;
    item.move_ticks = ticks;
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= item;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_item(item);
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
  endtask

  // APB write: setup cycle, access cycle, then back to idle
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic axis, input logic [15:0] f0, input logic [15:0] f1,
                            input logic [15:0] f2, input logic [15:0] f3,
                            input logic [15:0] step);
    wait_drained();
    cfg_write(REG_AXIS_MODE, {31'd0, axis});
    cfg_write(REG_FREQ_LVL0, {16'd0, f0});
    cfg_write(REG_FREQ_LVL1, {16'd0, f1});
    cfg_write(REG_FREQ_LVL2, {16'd0, f2});
    cfg_write(REG_FREQ_LVL3, {16'd0, f3});
    cfg_write(REG_STEP_TICKS, {16'd0, step});
    phases_run++;
  endtask

  // Mostly whole moves: a start with random direction and length, then a random run of ticks
  // that may ramp up, hold and brake to zero, with stray stop ticks and undefined ops mixed in.
  // The rest is loose noise. Undefined ops do not count toward n.
  task automatic random_traffic(input int n);
    int          done;
    int          len;
    int unsigned span;
    int unsigned r;
    logic [1:0]  op;
    logic [31:0] ticks;
    done = 0;
    span = sb.step_ticks * RAMP_LEVELS * 2 + 6;
    if (span > 80) span = 80;
    while (done < n) begin
      if ($urandom_range(99) < 80) begin
        r = $urandom_range(99);
        if (r < 70)      ticks = $urandom_range(span);
        else if (r < 80) ticks = 32'd0;
        else if (r < 90) ticks = 32'hFFFF_FFFF;
        else             ticks = $urandom;
        send_item(OP_START, 2'($urandom_range(3)), ticks);
        done++;
        len = $urandom_range(span + span / 2, 1);
        for (int k = 0; k < len; k++) begin
          r = $urandom_range(99);
          if (r < 3) begin
            send_item(OP_UNDEF, 2'($urandom_range(3)), $urandom);
          end else begin
            send_item((r < 12) ? OP_STOP : OP_RUN, 2'($urandom_range(3)), $urandom);
            done++;
          end
        end
      end else begin
        op = 2'($urandom_range(3));
        send_item(op, 2'($urandom_range(3)), $urandom);
        if (op != OP_UNDEF) done++;
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    hold_req       = 1'b0;
    phases_run     = 0;
    sb             = new();
    set_idling(IDLE_NONE);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state under the default registers, including an undefined op
    send_item(OP_RUN, DIR_RIGHT, 32'd0);
    send_item(OP_UNDEF, DIR_DOWN, 32'hFFFF_FFFF);
    send_item(OP_STOP, DIR_RIGHT, 32'd0);
    send_item(OP_START, DIR_RIGHT, 32'd0);
    send_item(OP_RUN, DIR_RIGHT, 32'd0);

    // Short levels: ramp through every entry, hold the top, brake down to zero
    set_config(1'b0, 16'd100, 16'd200, 16'd300, 16'd400, 16'd1);
    send_item(OP_START, DIR_RIGHT, 32'd6);
    repeat (6) send_item(OP_RUN, DIR_LEFT, 32'd0);
    repeat (4) send_item(OP_RUN, DIR_UP, 32'd0);
    // Endless move cut short by forced stops
    send_item(OP_START, DIR_LEFT, 32'hFFFF_FFFF);
    repeat (2) send_item(OP_RUN, DIR_RIGHT, 32'd0);
    repeat (3) send_item(OP_STOP, DIR_RIGHT, 32'd0);
    // Flip to the dual axis with state kept, then up and down moves
    wait_drained();
    cfg_write(REG_AXIS_MODE, 32'd1);
    send_item(OP_START, DIR_UP, 32'd2);
    repeat (2) send_item(OP_RUN, DIR_DOWN, 32'd0);
    send_item(OP_START, DIR_DOWN, 32'd1);
    send_item(OP_RUN, DIR_UP, 32'd0);

    // Default table, no idling, and a long receiver hold-off at the start
    set_config(1'b0, RST_FREQ_LVL0, RST_FREQ_LVL1, RST_FREQ_LVL2, RST_FREQ_LVL3, 16'd3);
    hold_req = 1'b1;
    random_traffic(230);

    // Random table, fastest step, sender gaps
    set_config(1'b1, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)), 16'd1);
    set_idling(IDLE_SENDER);
    random_traffic(230);

    // Duplicate and zero entries, receiver stalls; pause midway to toggle the axis mode
    set_config(1'b0, 16'd0, 16'd700, 16'd700, 16'd1500, 16'd5);
    set_idling(IDLE_RECEIVER);
    random_traffic(115);
    wait_drained();
    cfg_write(REG_AXIS_MODE, 32'd1);
    random_traffic(115);

    // Extreme frequencies, light idling on both sides
    set_config(1'b1, 16'd0, 16'hFFFF, 16'h8000, 16'hFFFF, 16'd2);
    set_idling(IDLE_BOTH);
    random_traffic(230);

    // Random table and small step, no idling
    set_config(1'b0, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(8, 1)));
    set_idling(IDLE_NONE);
    random_traffic(230);

    // Largest step: the ramp barely leaves its first level
    set_config(1'b1, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)), 16'hFFFF);
    set_idling(IDLE_SENDER);
    random_traffic(60);

    // Zero step: the moving phase loads nothing
    set_config(1'b0, 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)), 16'd0);
    set_idling(IDLE_RECEIVER);
    random_traffic(40);

    // Last table, cycle through every idling pattern
    set_config(1'($urandom_range(1)), 16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), 16'($urandom_range(65535)),
               16'($urandom_range(6, 1)));
    for (int m = 0; m < 4; m++) begin
      set_idling(idle_mode_e'(m));
      random_traffic(50);
    end

    // Drain, then watch a while longer for stray results
    wait_drained();
    repeat (20) @(posedge clk);
    $display("summary: %0d items over %0d register setups, %0d results checked, %0d mismatches",
             sb.items_seen, phases_run, sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
